// ----- rtl/core/scpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Strand control point generator package
// Widths, codes, controller/datapath interface types and length saturation.
// ----------------------------------------------------------------------------
package scpg_pkg;

  localparam int MAX_SEGMENTS_DEF = 63;

  localparam int CNT_W   = 6;
  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int LEN_W   = 31;
  localparam int RATIO_W = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Q.24 lengths saturate at 2^40, so they need 41 bits
  localparam int SEG_W   = 41;
  localparam int DIST_W  = 47;
  localparam int LO_W    = 24;
  localparam int HI_W    = DIST_W - LO_W;
  localparam int PROD_W  = SEG_W + RATIO_W;
  localparam int CAPIN_W = PROD_W - 14;
  localparam int DVD_W   = LEN_W + 32;
  localparam int DVS_W   = SEG_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd2;

  localparam logic [SEG_W-1:0] LEN_CAP = SEG_W'(1) << 40;
  localparam logic [SEG_W-1:0] ONE_Q24 = SEG_W'(1) << 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNIFORM = 2'd0,
    MODE_ARITH   = 2'd1,
    MODE_GEO     = 2'd2,
    MODE_NONE    = 2'd3
  } spacing_t;

  typedef enum logic [1:0] {
    DIV_LEN,
    DIV_AVG,
    DIV_GEO
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PADD,
    ST_EMIT,
    ST_GCHK,
    ST_GMUL,
    ST_GACC,
    ST_DIVA,
    ST_DIVA_W,
    ST_DIVB,
    ST_DIVB_W,
    ST_SEG,
    ST_DADD
  } state_t;

  typedef struct packed {
    logic    load;
    logic    pmul;
    logic    padd;
    logic    emit;
    logic    gmul;
    logic    gacc;
    logic    div_start;
    div_op_t div_op;
    logic    cap_a;
    logic    cap_b;
    logic    seg_calc;
    logic    dist_add;
  } cmd_t;

  typedef struct packed {
    spacing_t mode;
    logic     root;
    logic     last;
    logic     out_free;
    logic     g_more;
    logic     div_done;
  } sts_t;

  function automatic logic [SEG_W-1:0] cap_len(input logic [CAPIN_W-1:0] v);
    logic [SEG_W-1:0] r;
    if (v > CAPIN_W'(LEN_CAP)) begin
      r = LEN_CAP;
    end else begin
      r = v[SEG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/strand_control_point_generator.sv -----
// ----------------------------------------------------------------------------
// Strand control point generator
// Walks N segments from a strand root along a direction and emits N+1 points (only the root in MODE_NONE).
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | start xyz, dir xyz, strand_length
//  out     | output    | out_valid/out_stall | point xyz, point_index, last_point
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item at a time. The root point is placed first. Setup: one serial
//  divide (uniform), two (arithmetic), or a ratio power loop plus one
//  divide (geometric). Then each point runs through the shared placement
//  multiply/add sequence.
//  Reset is synchronous, active low, and loads the register defaults.
//  A stalled output holds in the output register while the walk advances
//  to the next point.
// ----------------------------------------------------------------------------
module strand_control_point_generator
  import scpg_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic signed [DIR_W-1:0]   in_dir_x,
  input  logic signed [DIR_W-1:0]   in_dir_y,
  input  logic signed [DIR_W-1:0]   in_dir_z,
  input  logic [LEN_W-1:0]          in_strand_length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic signed [COORD_W-1:0] out_point_z,
  output logic [CNT_W-1:0]          out_point_index,
  output logic                      out_last_point,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  scpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scpg_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .in_strand_length (in_strand_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_point_index  (out_point_index),
    .out_last_point   (out_last_point)
  );

endmodule

// ----- rtl/core/scpg_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; done pulses on the cycle after the last
// quotient bit.
// ----------------------------------------------------------------------------
module scpg_div
  import scpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVD_W-1:0]     quot_r;
  logic [DVS_W-1:0]     dvs_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quot_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DVD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- rtl/core/scpg_dp.sv -----
// ----------------------------------------------------------------------------
// Strand control point datapath
// Config registers, segment length math, distance walk, point placement
// and the output register.
// ----------------------------------------------------------------------------
module scpg_dp
  import scpg_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic signed [DIR_W-1:0]   in_dir_x,
  input  logic signed [DIR_W-1:0]   in_dir_y,
  input  logic signed [DIR_W-1:0]   in_dir_z,
  input  logic [LEN_W-1:0]          in_strand_length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic signed [COORD_W-1:0] out_point_z,
  output logic [CNT_W-1:0]          out_point_index,
  output logic                      out_last_point
);

  spacing_t             mode_r;
  logic [CNT_W-1:0]     count_r;
  logic [RATIO_W-1:0]   ratio_r;

  logic signed [COORD_W-1:0] st_r  [3];
  logic signed [DIR_W-1:0]   dir_r [3];
  logic [LEN_W-1:0]          len_r;

  logic [DIST_W-1:0]  dist_r;
  logic [SEG_W-1:0]   seg_r;
  logic [SEG_W-1:0]   avg_r;
  logic [SEG_W-1:0]   step_r;
  logic [SEG_W-1:0]   p_r;
  logic [SEG_W-1:0]   s_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CNT_W-1:0]   g_r;
  logic [CNT_W-1:0]   pidx_r;

  logic [DIR_W+LO_W-1:0] lo_r [3];
  logic [DIR_W+HI_W-1:0] hi_r [3];
  logic signed [COORD_W-1:0] pt_r [3];

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_pt_r [3];
  logic [CNT_W-1:0]          out_idx_r;
  logic                      out_last_r;

  logic [CNT_W-1:0]  n_eff;
  logic [DIR_W-1:0]  mag [3];
  logic signed [COORD_W-1:0] pos_nxt [3];
  logic [SEG_W-1:0]  prod_cap;
  logic [SEG_W-1:0]  sum_cap;
  logic [SEG_W-1:0]  seg_arith;
  logic              is_last;
  logic              out_free;

  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;

  // clamp the segment count into 1..MAX_SEGMENTS
  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_r > CNT_W'(MAX_SEGMENTS)) begin
      n_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_eff = count_r;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_UNIFORM;
      count_r <= CNT_W'(8);
      ratio_r <= RATIO_W'(16384);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= spacing_t'(cfg_data[MODE_W-1:0]);
        CFG_COUNT: count_r <= cfg_data[CNT_W-1:0];
        CFG_RATIO: ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // divider operands
  always_comb begin
    case (cmd.div_op)
      DIV_LEN: begin
        div_dvd = DVD_W'({len_r, 8'b0});
        div_dvs = DVS_W'(n_eff);
      end
      DIV_AVG: begin
        div_dvd = DVD_W'(avg_r);
        div_dvs = DVS_W'(n_eff);
      end
      DIV_GEO: begin
        div_dvd = {len_r, 32'b0};
        div_dvs = s_r;
      end
      default: begin
        div_dvd = '0;
        div_dvs = DVS_W'(1);
      end
    endcase
  end

  scpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  // arithmetic mode: seg = avg + k*step, the zero step skipped for even counts
  always_comb begin
    logic [CNT_W-1:0]       half;
    logic signed [CNT_W+1:0] k;
    logic signed [SEG_W+CNT_W+2:0] sum;
    half = n_eff >> 1;
    k    = $signed({2'b0, pidx_r}) - $signed({2'b0, half});
    if (!n_eff[0] && (pidx_r >= half)) begin
      k = k + (CNT_W+2)'(1);
    end
    sum = $signed((SEG_W+CNT_W+3)'(avg_r))
        + (SEG_W+CNT_W+3)'(k * $signed({1'b0, step_r}));
    seg_arith = sum[SEG_W-1:0];
  end

  always_comb begin
    prod_cap = cap_len(prod_r[PROD_W-1:14]);
    sum_cap  = cap_len(CAPIN_W'(s_r) + CAPIN_W'(prod_cap));
  end

  // place: start +- round(|dir| * dist / 2^22), saturated
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [DVD_W-1:0]   full;
      logic [SEG_W-1:0]   off;
      logic signed [COORD_W+10:0] pos;
      mag[c] = dir_r[c][DIR_W-1] ? DIR_W'(~dir_r[c] + 1'b1) : DIR_W'(dir_r[c]);
      full = {hi_r[c], LO_W'(0)} + DVD_W'(lo_r[c]) + (DVD_W'(1) << 21);
      off  = full[DVD_W-1:22];
      if (dir_r[c][DIR_W-1]) begin
        pos = (COORD_W+11)'(st_r[c]) - $signed((COORD_W+11)'(off));
      end else begin
        pos = (COORD_W+11)'(st_r[c]) + $signed((COORD_W+11)'(off));
      end
      if (pos > (COORD_W+11)'(32'sh7FFF_FFFF)) begin
        pos_nxt[c] = 32'sh7FFF_FFFF;
      end else if (pos < (COORD_W+11)'(32'sh8000_0000)) begin
        pos_nxt[c] = 32'sh8000_0000;
      end else begin
        pos_nxt[c] = pos[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r[0]  <= in_start_x;
      st_r[1]  <= in_start_y;
      st_r[2]  <= in_start_z;
      dir_r[0] <= in_dir_x;
      dir_r[1] <= in_dir_y;
      dir_r[2] <= in_dir_z;
      len_r    <= in_strand_length;
      dist_r   <= '0;
      p_r      <= ONE_Q24;
      s_r      <= ONE_Q24;
      g_r      <= CNT_W'(1);
      pidx_r   <= '0;
    end
    if (cmd.pmul) begin
      for (int c = 0; c < 3; c++) begin
        lo_r[c] <= (DIR_W+LO_W)'(mag[c]) * (DIR_W+LO_W)'(dist_r[LO_W-1:0]);
        hi_r[c] <= (DIR_W+HI_W)'(mag[c]) * (DIR_W+HI_W)'(dist_r[DIST_W-1:LO_W]);
      end
      prod_r <= PROD_W'(seg_r) * PROD_W'(ratio_r);
    end
    if (cmd.padd) begin
      for (int c = 0; c < 3; c++) begin
        pt_r[c] <= pos_nxt[c];
      end
      // geometric growth of the next segment
      if (mode_r == MODE_GEO && pidx_r != '0) begin
        seg_r <= prod_cap;
      end
    end
    if (cmd.gmul) begin
      prod_r <= PROD_W'(p_r) * PROD_W'(ratio_r);
    end
    if (cmd.gacc) begin
      p_r <= prod_cap;
      s_r <= sum_cap;
      g_r <= g_r + 1'b1;
    end
    if (cmd.cap_a) begin
      if (mode_r == MODE_ARITH) begin
        avg_r <= div_q[SEG_W-1:0];
      end else begin
        seg_r <= div_q[SEG_W-1:0];
      end
    end
    if (cmd.cap_b) begin
      step_r <= div_q[SEG_W-1:0];
    end
    if (cmd.seg_calc && mode_r == MODE_ARITH) begin
      seg_r <= seg_arith;
    end
    if (cmd.dist_add) begin
      dist_r <= dist_r + DIST_W'(seg_r);
      pidx_r <= pidx_r + 1'b1;
    end
  end

  assign is_last  = (mode_r == MODE_NONE) || (pidx_r == n_eff);
  assign out_free = !out_valid_r || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int c = 0; c < 3; c++) begin
        out_pt_r[c] <= pt_r[c];
      end
      out_idx_r  <= pidx_r;
      out_last_r <= is_last;
    end
  end

  always_comb begin
    sts.mode     = mode_r;
    sts.root     = (pidx_r == '0);
    sts.last     = is_last;
    sts.out_free = out_free;
    sts.g_more   = (g_r < n_eff);
    sts.div_done = div_done;
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_pt_r[0];
  assign out_point_y     = out_pt_r[1];
  assign out_point_z     = out_pt_r[2];
  assign out_point_index = out_idx_r;
  assign out_last_point  = out_last_r;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("point loaded over a result still held");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dist_add |-> (pidx_r < n_eff))
    else $error("walk past the last segment");

  a_cap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cap_a || cmd.cap_b) |-> div_done)
    else $error("quotient taken before divider finished");
`endif

endmodule

// ----- rtl/core/scpg_ctrl.sv -----
// ----------------------------------------------------------------------------
// Strand control point controller
// Sequences root placement, segment setup and the per-point walk.
// ----------------------------------------------------------------------------
module scpg_ctrl
  import scpg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PMUL;
      ST_PMUL:   state_nxt = ST_PADD;
      ST_PADD:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else if (!sts.root) begin
            state_nxt = ST_SEG;
          end else if (sts.mode == MODE_GEO) begin
            state_nxt = ST_GCHK;
          end else begin
            state_nxt = ST_DIVA;
          end
        end
      end
      ST_GCHK:   state_nxt = sts.g_more ? ST_GMUL : ST_DIVA;
      ST_GMUL:   state_nxt = ST_GACC;
      ST_GACC:   state_nxt = ST_GCHK;
      ST_DIVA:   state_nxt = ST_DIVA_W;
      ST_DIVA_W: begin
        if (sts.div_done) begin
          state_nxt = (sts.mode == MODE_ARITH) ? ST_DIVB : ST_SEG;
        end
      end
      ST_DIVB:   state_nxt = ST_DIVB_W;
      ST_DIVB_W: if (sts.div_done) state_nxt = ST_SEG;
      ST_SEG:    state_nxt = ST_DADD;
      ST_DADD:   state_nxt = ST_PMUL;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = DIV_LEN;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PMUL:   cmd.pmul = 1'b1;
      ST_PADD:   cmd.padd = 1'b1;
      ST_EMIT:   cmd.emit = sts.out_free;
      ST_GMUL:   cmd.gmul = 1'b1;
      ST_GACC:   cmd.gacc = 1'b1;
      ST_DIVA: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = (sts.mode == MODE_GEO) ? DIV_GEO : DIV_LEN;
      end
      ST_DIVA_W: cmd.cap_a = sts.div_done;
      ST_DIVB: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_AVG;
      end
      ST_DIVB_W: cmd.cap_b = sts.div_done;
      ST_SEG:    cmd.seg_calc = 1'b1;
      ST_DADD:   cmd.dist_add = 1'b1;
      default: ;
    endcase
  end

endmodule
